// ===== sv/sjf_pkg.sv =====
package sjf_pkg;

  localparam int MAX_TASKS_DEF  = 32;
  localparam int BURST_BITS_DEF = 16;

  localparam int ID_W      = 6;
  localparam int BURST_W   = 16;
  localparam int TIME_W    = 21;
  localparam int TOTAL_W   = 26;
  localparam int ELAPSED_W = 22;
  localparam int ERR_W     = 2;

  localparam int FIELDS_W = ID_W + BURST_W + 2 * TIME_W + 2 * TOTAL_W;
  localparam int OUT_W    = ((FIELDS_W + 7) / 8) * 8;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== sv/sjf_cell.sv =====
module sjf_cell #(
  parameter int BURST_BITS = sjf_pkg::BURST_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sjf_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     nbr_valid_i,
  input  logic [BURST_BITS-1:0]    nbr_burst_i,
  input  logic [sjf_pkg::ID_W-1:0] nbr_id_i,
  input  logic [BURST_BITS-1:0]    load_burst_i,
  input  logic [sjf_pkg::ID_W-1:0] load_id_i,
  output logic                     valid_o,
  output logic [BURST_BITS-1:0]    burst_o,
  output logic [sjf_pkg::ID_W-1:0] id_o
);
  import sjf_pkg::*;

  logic                  valid_q;
  logic [BURST_BITS-1:0] burst_q;
  logic [ID_W-1:0]       id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end else if (ctrl_i.shift) begin
      valid_q <= nbr_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      burst_q <= load_burst_i;
      id_q    <= load_id_i;
    end else if (ctrl_i.shift) begin
      burst_q <= nbr_burst_i;
      id_q    <= nbr_id_i;
    end
  end

  assign valid_o = valid_q;
  assign burst_o = burst_q;
  assign id_o    = id_q;

endmodule

// ===== sv/shortest_job_first_scheduler.sv =====
// Channel  Dir  tdata (low bit up)                              tuser   tlast
// s_axis   in   burst[15:0]                                     mode    -
// m_axis   out  task_id, task_burst, start_time, finish_time,   error   last
//               total_wait, total_turnaround, 4 zero bits
// A run, for each dispatched task, rotates the whole ring of cells past the
// comparator at its head, then rotates on to bring the chosen cell to the
// head and drops it. Reset clears the valid bits, the task count and the
// controller; stored bursts and ids are not reset. A full output register
// holds the controller.
module shortest_job_first_scheduler #(
  parameter int MAX_TASKS  = sjf_pkg::MAX_TASKS_DEF,
  parameter int BURST_BITS = sjf_pkg::BURST_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [sjf_pkg::BURST_W-1:0] s_axis_tdata_i,  // burst
  input  logic                      s_axis_tuser_i,  // mode
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // task_id, task_burst, start_time, finish_time, total_wait, total_turnaround
  output logic [sjf_pkg::OUT_W-1:0] m_axis_tdata_o,
  output logic [sjf_pkg::ERR_W-1:0] m_axis_tuser_o,  // error
  output logic                      m_axis_tlast_o
);
  import sjf_pkg::*;

  localparam int BW = (BURST_BITS < BURST_W) ? BURST_BITS : BURST_W;
  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_SEEK = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic [IW-1:0]        best_off_q, best_off_d;
  logic [BW-1:0]        best_burst_q, best_burst_d;
  logic [ID_W-1:0]      best_id_q, best_id_d;
  logic                 found_q, found_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [TOTAL_W-1:0]   tw_q, tw_d;
  logic [TOTAL_W-1:0]   tt_q, tt_d;

  logic          item_mode_q;
  logic [BW-1:0] item_burst_q;

  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q, out_data_d;
  err_e             m_err_q, out_err_d;
  logic             m_last_q, out_last_d;
  logic             out_load;
  logic             out_free;

  logic                 rotate;
  logic                 kill;
  logic                 add_we;
  logic [ELAPSED_W-1:0] fin;

  logic            cell_valid [MAX_TASKS];
  logic [BW-1:0]   cell_burst [MAX_TASKS];
  logic [ID_W-1:0] cell_id    [MAX_TASKS];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign fin             = elapsed_q + ELAPSED_W'(best_burst_q);

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic            nbr_valid;
    logic [BW-1:0]   nbr_burst;
    logic [ID_W-1:0] nbr_id;

    assign ctrl.shift = rotate;
    assign ctrl.load  = add_we && (count_q[IW-1:0] == IW'(i));

    if (i == MAX_TASKS - 1) begin : g_wrap
      assign nbr_valid = cell_valid[0] && !kill;
      assign nbr_burst = cell_burst[0];
      assign nbr_id    = cell_id[0];
    end else begin : g_link
      assign nbr_valid = cell_valid[i+1];
      assign nbr_burst = cell_burst[i+1];
      assign nbr_id    = cell_id[i+1];
    end

    sjf_cell #(
      .BURST_BITS(BW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .nbr_valid_i (nbr_valid),
      .nbr_burst_i (nbr_burst),
      .nbr_id_i    (nbr_id),
      .load_burst_i(item_burst_q),
      .load_id_i   (ID_W'(count_q + CW'(1))),
      .valid_o     (cell_valid[i]),
      .burst_o     (cell_burst[i]),
      .id_o        (cell_id[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cnt_d        = cnt_q;
    best_off_d   = best_off_q;
    best_burst_d = best_burst_q;
    best_id_d    = best_id_q;
    found_d      = found_q;
    elapsed_d    = elapsed_q;
    tw_d         = tw_q;
    tt_d         = tt_q;
    rotate       = 1'b0;
    kill         = 1'b0;
    add_we       = 1'b0;
    out_load     = 1'b0;
    out_data_d   = '0;
    out_err_d    = ERR_NONE;
    out_last_d   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          if (item_mode_q == MODE_ADD) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
            if (count_q == CW'(MAX_TASKS)) begin
              out_err_d = ERR_FULL;
            end else begin
              add_we     = 1'b1;
              count_d    = count_q + CW'(1);
              out_data_d = OUT_W'({BURST_W'(item_burst_q), ID_W'(count_q + CW'(1))});
            end
          end else if (count_q == '0) begin
            out_load  = 1'b1;
            out_err_d = ERR_EMPTY;
            state_d   = ST_IDLE;
          end else begin
            elapsed_d = '0;
            tw_d      = '0;
            tt_d      = '0;
            cnt_d     = '0;
            found_d   = 1'b0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rotate = 1'b1;
        if (cell_valid[0] && (!found_q || cell_burst[0] < best_burst_q)) begin
          found_d      = 1'b1;
          best_off_d   = cnt_q;
          best_burst_d = cell_burst[0];
          best_id_d    = cell_id[0];
        end
        if (cnt_q == IW'(MAX_TASKS - 1)) begin
          cnt_d   = '0;
          state_d = ST_SEEK;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      ST_SEEK: begin
        if (cnt_q == best_off_q) begin
          if (out_free) begin
            rotate     = 1'b1;
            kill       = 1'b1;
            out_load   = 1'b1;
            out_last_d = (count_q == CW'(1));
            out_data_d = OUT_W'({tt_q + TOTAL_W'(fin), tw_q + TOTAL_W'(elapsed_q),
                                 fin[TIME_W-1:0], elapsed_q[TIME_W-1:0],
                                 BURST_W'(best_burst_q), best_id_q});
            elapsed_d  = fin;
            tw_d       = tw_q + TOTAL_W'(elapsed_q);
            tt_d       = tt_q + TOTAL_W'(fin);
            count_d    = count_q - CW'(1);
            found_d    = 1'b0;
            cnt_d      = '0;
            state_d    = (count_q == CW'(1)) ? ST_IDLE : ST_SCAN;
          end
        end else begin
          rotate = 1'b1;
          cnt_d  = cnt_q + IW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_off_q   <= best_off_d;
    best_burst_q <= best_burst_d;
    best_id_q    <= best_id_d;
    elapsed_q    <= elapsed_d;
    tw_q         <= tw_d;
    tt_q         <= tt_d;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_mode_q  <= s_axis_tuser_i;
      item_burst_q <= s_axis_tdata_i[BW-1:0];
    end
    if (out_load) begin
      m_data_q <= out_data_d;
      m_err_q  <= out_err_d;
      m_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_err_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule
